### rtl/ogbt_pkg.sv
// ----------------------------------------------------------------------------
// ogbt_pkg
// Shared types and constants of the occupancy grid block threshold design.
// ----------------------------------------------------------------------------
package ogbt_pkg;

    localparam int DEF_MAX_WIDTH   = 64;
    localparam int DEF_MAX_HEIGHT  = 64;
    localparam int DEF_SAMPLE_BITS = 16;

    localparam int POS_W      = 6;
    localparam int DIM_W      = 7;
    localparam int THR_W      = 16;
    localparam int CFG_W      = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int IN_VAL_W   = 16;
    localparam int FRAC_BITS  = 16;
    localparam int DIV_BITS   = 6;
    localparam int DIV_CNT_W  = 3;

    localparam logic [CFG_IDX_W-1:0] CFG_GRID_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GRID_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CELL_SIDE   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD   = 2'd3;

    localparam logic [DIM_W-1:0] RST_GRID_WIDTH  = 7'd64;
    localparam logic [DIM_W-1:0] RST_GRID_HEIGHT = 7'd64;
    localparam logic [DIM_W-1:0] RST_CELL_SIDE   = 7'd4;
    localparam logic [THR_W-1:0] RST_THRESHOLD   = 16'd32768;

    localparam logic REQ_WRITE = 1'b0;
    localparam logic REQ_QUERY = 1'b1;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SCAN,
        ST_SCAN_END,
        ST_DIV_X,
        ST_DIV_Y,
        ST_SETUP,
        ST_BLOCK,
        ST_BLOCK_END,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic                start;
        logic [DIV_BITS-1:0] dividend;
        logic [DIM_W-1:0]    divisor;
    } div_req_t;

    typedef struct packed {
        logic                done;
        logic [DIV_BITS-1:0] quot;
        logic [DIM_W-1:0]    rem;
    } div_rsp_t;

endpackage

### rtl/ogbt_sample_mem.sv
// ----------------------------------------------------------------------------
// ogbt_sample_mem
// Sample store: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module ogbt_sample_mem #(
    parameter int ADDR_W = 12,
    parameter int DATA_W = 16
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [DATA_W-1:0] wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [DATA_W-1:0] rdata
);

    localparam int DEPTH = 1 << ADDR_W;

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

### rtl/ogbt_div.sv
// ----------------------------------------------------------------------------
// ogbt_div
// Restoring divider, one quotient bit per cycle, shared by both grid axes.
// ----------------------------------------------------------------------------
module ogbt_div (
    input  logic              clk,
    input  logic              rst_n,
    input  ogbt_pkg::div_req_t req,
    output ogbt_pkg::div_rsp_t rsp
);
    import ogbt_pkg::*;

    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic [DIV_BITS-1:0]  dvd_reg, dvd_next;
    logic [DIV_BITS-1:0]  quot_reg, quot_next;
    logic [DIM_W-1:0]     rem_reg, rem_next;
    logic [DIM_W-1:0]     dsr_reg, dsr_next;
    logic [DIM_W:0]       trial;
    logic [DIM_W:0]       diff;
    logic                 fits;

    assign trial = {rem_reg, dvd_reg[DIV_BITS-1]};
    assign fits  = trial >= {1'b0, dsr_reg};
    assign diff  = trial - {1'b0, dsr_reg};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        dvd_next  = dvd_reg;
        quot_next = quot_reg;
        rem_next  = rem_reg;
        dsr_next  = dsr_reg;
        if (req.start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            dvd_next  = req.dividend;
            quot_next = '0;
            rem_next  = '0;
            dsr_next  = req.divisor;
        end
        else if (busy_reg)
        begin
            dvd_next  = {dvd_reg[DIV_BITS-2:0], 1'b0};
            quot_next = {quot_reg[DIV_BITS-2:0], fits};
            rem_next  = fits ? diff[DIM_W-1:0] : trial[DIM_W-1:0];
            cnt_next  = cnt_reg + 1'b1;
            if (cnt_reg == DIV_CNT_W'(DIV_BITS - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cnt_reg  <= cnt_next;
        dvd_reg  <= dvd_next;
        quot_reg <= quot_next;
        rem_reg  <= rem_next;
        dsr_reg  <= dsr_next;
    end

    assign rsp.done = done_reg;
    assign rsp.quot = quot_reg;
    assign rsp.rem  = rem_reg;

    a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        req.start |-> !busy_reg)
        else $error("divider started while busy");

    a_done_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> !busy_reg)
        else $error("divider done while still busy");

    a_rem_below: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> rem_reg < dsr_reg)
        else $error("divider remainder not below divisor");

endmodule

### rtl/occupancy_grid_block_threshold.sv
// ----------------------------------------------------------------------------
// occupancy_grid_block_threshold
// Dense sample grid with coarse cell occupancy query against a normalized
// threshold, computed by one shared compare and divide path under a sequencer.
// ----------------------------------------------------------------------------
// write beat: no result; a query beat occupies the block (one read port: a
//   grid scan for min and max, two six-step divisions, then the cell scan,
//   which stops at the first hit)
// one query in flight; the next beat is taken while a result waits on out
// after reset a clearing pass zeroes all 2**(XW+YW) store entries (4096 at
//   default size), with in_ready low; config writes are taken meanwhile
// ----------------------------------------------------------------------------
module occupancy_grid_block_threshold #(
    parameter int MAX_WIDTH   = ogbt_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT  = ogbt_pkg::DEF_MAX_HEIGHT,
    parameter int SAMPLE_BITS = ogbt_pkg::DEF_SAMPLE_BITS
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [ogbt_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [ogbt_pkg::CFG_W-1:0]       cfg_data,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic                             req_type,
    input  logic [ogbt_pkg::POS_W-1:0]       pos_x,
    input  logic [ogbt_pkg::POS_W-1:0]       pos_y,
    input  logic signed [ogbt_pkg::IN_VAL_W-1:0] sample_value,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic                             occupied,
    output logic                             in_range,
    output logic                             flat
);
    import ogbt_pkg::*;

    localparam int EFF_W  = (MAX_WIDTH < 127) ? MAX_WIDTH : 127;
    localparam int EFF_H  = (MAX_HEIGHT < 127) ? MAX_HEIGHT : 127;
    localparam int XW     = $clog2(EFF_W);
    localparam int YW     = $clog2(EFF_H);
    localparam int ADDR_W = XW + YW;
    localparam int SB     = SAMPLE_BITS;
    localparam int PROD_W = SB + FRAC_BITS;
    localparam logic [DIM_W-1:0] W_LIM = DIM_W'(EFF_W);
    localparam logic [DIM_W-1:0] H_LIM = DIM_W'(EFF_H);

    state_t state_reg, state_next;

    logic [DIM_W-1:0]  gw_reg, gw_next;
    logic [DIM_W-1:0]  gh_reg, gh_next;
    logic [DIM_W-1:0]  cs_reg, cs_next;
    logic [THR_W-1:0]  thr_reg, thr_next;
    logic [ADDR_W-1:0] clr_reg, clr_next;
    logic              scan_vld_reg, scan_vld_next;
    logic              blk_vld_reg, blk_vld_next;
    logic              out_valid_reg, out_valid_next;

    logic [POS_W-1:0]     px_reg, px_next;
    logic [POS_W-1:0]     py_reg, py_next;
    logic [DIM_W-1:0]     cx_reg, cx_next;
    logic [DIM_W-1:0]     cy_reg, cy_next;
    logic                 first_reg, first_next;
    logic signed [SB-1:0] mn_reg, mn_next;
    logic signed [SB-1:0] mx_reg, mx_next;
    logic [DIM_W-1:0]     gx_reg, gx_next;
    logic [DIM_W-1:0]     gy_reg, gy_next;
    logic [DIM_W-1:0]     xs_reg, xs_next;
    logic [DIM_W-1:0]     ys_reg, ys_next;
    logic [DIM_W-1:0]     x0_reg, x0_next;
    logic [DIM_W-1:0]     y0_reg, y0_next;
    logic [PROD_W-1:0]    rhs_reg, rhs_next;
    logic                 occ_reg, occ_next;
    logic                 occupied_reg, occupied_next;
    logic                 in_range_reg, in_range_next;
    logic                 flat_reg, flat_next;

    logic [DIM_W-1:0]  w_eff, h_eff;
    logic              mem_we;
    logic [ADDR_W-1:0] mem_waddr, mem_raddr;
    logic [SB-1:0]     mem_wdata, mem_rdata;
    logic signed [SB-1:0] rd_val;
    logic [DIM_W-1:0]  rd_x, rd_y;
    logic [31:0]       sv_ext;
    logic [DIM_W-1:0]  px_ext, py_ext;
    div_req_t          div_req;
    div_rsp_t          div_rsp;
    logic [DIM_W:0]    twice_rem;
    logic              div_lsb;
    logic              mod_zero;
    logic              grid_flat;
    logic              cell_inr;
    logic [SB:0]       range_full;
    logic [SB:0]       d_full;
    logic [PROD_W-1:0] lhs;
    logic [PROD_W-1:0] rhs_prod;
    logic [12:0]       prod_x, prod_y;

    always_comb
    begin
        if (gw_reg == '0)
            w_eff = DIM_W'(1);
        else if (gw_reg > W_LIM)
            w_eff = W_LIM;
        else
            w_eff = gw_reg;
        if (gh_reg == '0)
            h_eff = DIM_W'(1);
        else if (gh_reg > H_LIM)
            h_eff = H_LIM;
        else
            h_eff = gh_reg;
    end

    assign px_ext    = {1'b0, px_reg};
    assign py_ext    = {1'b0, py_reg};
    assign sv_ext    = {{(32 - IN_VAL_W){sample_value[IN_VAL_W-1]}}, sample_value};
    assign rd_val    = $signed(mem_rdata);
    assign grid_flat = (mn_reg == mx_reg);
    assign cell_inr  = (px_ext < gx_reg) && (py_ext < gy_reg);

    assign range_full = {mx_reg[SB-1], mx_reg} - {mn_reg[SB-1], mn_reg};
    assign rhs_prod   = {{SB{1'b0}}, thr_reg} * {{FRAC_BITS{1'b0}}, range_full[SB-1:0]};
    assign d_full     = {rd_val[SB-1], rd_val} - {mn_reg[SB-1], mn_reg};
    assign lhs        = {d_full[SB-1:0], {FRAC_BITS{1'b0}}};
    assign prod_x     = 13'(px_reg) * 13'(cs_reg);
    assign prod_y     = 13'(py_reg) * 13'(cs_reg);

    // w or h mod s is zero when twice the half remainder plus the odd bit is 0 or s
    assign div_lsb   = (state_reg == ST_DIV_X) ? w_eff[0] : h_eff[0];
    assign twice_rem = {div_rsp.rem, div_lsb};
    assign mod_zero  = (twice_rem == '0) || (twice_rem == {1'b0, cs_reg});

    assign rd_x      = (state_reg == ST_BLOCK) ? DIM_W'(x0_reg + cx_reg) : cx_reg;
    assign rd_y      = (state_reg == ST_BLOCK) ? DIM_W'(y0_reg + cy_reg) : cy_reg;
    assign mem_raddr = {rd_y[YW-1:0], rd_x[XW-1:0]};

    always_comb
    begin
        state_next     = state_reg;
        gw_next        = gw_reg;
        gh_next        = gh_reg;
        cs_next        = cs_reg;
        thr_next       = thr_reg;
        clr_next       = clr_reg;
        scan_vld_next  = 1'b0;
        blk_vld_next   = 1'b0;
        out_valid_next = out_valid_reg;
        px_next        = px_reg;
        py_next        = py_reg;
        cx_next        = cx_reg;
        cy_next        = cy_reg;
        first_next     = first_reg;
        mn_next        = mn_reg;
        mx_next        = mx_reg;
        gx_next        = gx_reg;
        gy_next        = gy_reg;
        xs_next        = xs_reg;
        ys_next        = ys_reg;
        x0_next        = x0_reg;
        y0_next        = y0_reg;
        rhs_next       = rhs_reg;
        occ_next       = occ_reg;
        occupied_next  = occupied_reg;
        in_range_next  = in_range_reg;
        flat_next      = flat_reg;
        in_ready       = 1'b0;
        mem_we         = 1'b0;
        mem_waddr      = {py_ext[YW-1:0], px_ext[XW-1:0]};
        mem_wdata      = sv_ext[SB-1:0];
        div_req.start    = 1'b0;
        div_req.dividend = w_eff[DIM_W-1:1];
        div_req.divisor  = cs_reg;

        if (cfg_we)
        begin
            case (cfg_index)
                CFG_GRID_WIDTH:  gw_next  = cfg_data[DIM_W-1:0];
                CFG_GRID_HEIGHT: gh_next  = cfg_data[DIM_W-1:0];
                CFG_CELL_SIDE:   cs_next  = cfg_data[DIM_W-1:0];
                CFG_THRESHOLD:   thr_next = cfg_data[THR_W-1:0];
                default:         ;
            endcase
        end

        if (out_valid_reg && out_ready)
            out_valid_next = 1'b0;

        // min and max over the grid scan
        if (scan_vld_reg)
        begin
            if (first_reg || (rd_val < mn_reg))
                mn_next = rd_val;
            if (first_reg || (rd_val > mx_reg))
                mx_next = rd_val;
            first_next = 1'b0;
        end

        if (blk_vld_reg && (lhs > rhs_reg))
            occ_next = 1'b1;

        case (state_reg)
            ST_CLEAR:
            begin
                mem_we    = 1'b1;
                mem_waddr = clr_reg;
                mem_wdata = '0;
                clr_next  = clr_reg + 1'b1;
                if (clr_reg == '1)
                    state_next = ST_IDLE;
            end
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    if (req_type == REQ_WRITE)
                    begin
                        mem_waddr[ADDR_W-1:XW] = YW'({1'b0, pos_y});
                        mem_waddr[XW-1:0]      = XW'({1'b0, pos_x});
                        mem_we = ({1'b0, pos_x} < w_eff) && ({1'b0, pos_y} < h_eff);
                    end
                    else
                    begin
                        px_next    = pos_x;
                        py_next    = pos_y;
                        cx_next    = '0;
                        cy_next    = '0;
                        first_next = 1'b1;
                        occ_next   = 1'b0;
                        state_next = ST_SCAN;
                    end
                end
            end
            ST_SCAN:
            begin
                scan_vld_next = 1'b1;
                if (cx_reg == w_eff - 1'b1)
                begin
                    cx_next = '0;
                    if (cy_reg == h_eff - 1'b1)
                        state_next = ST_SCAN_END;
                    else
                        cy_next = cy_reg + 1'b1;
                end
                else
                begin
                    cx_next = cx_reg + 1'b1;
                end
            end
            ST_SCAN_END:
            begin
                if (cs_reg == '0)
                begin
                    gx_next    = '0;
                    gy_next    = '0;
                    state_next = ST_SETUP;
                end
                else
                begin
                    div_req.start = 1'b1;
                    state_next    = ST_DIV_X;
                end
            end
            ST_DIV_X:
            begin
                if (div_rsp.done)
                begin
                    gx_next          = {div_rsp.quot, 1'b0};
                    xs_next          = mod_zero ? '0 : div_rsp.rem;
                    div_req.start    = 1'b1;
                    div_req.dividend = h_eff[DIM_W-1:1];
                    state_next       = ST_DIV_Y;
                end
            end
            ST_DIV_Y:
            begin
                if (div_rsp.done)
                begin
                    gy_next    = {div_rsp.quot, 1'b0};
                    ys_next    = mod_zero ? '0 : div_rsp.rem;
                    state_next = ST_SETUP;
                end
            end
            ST_SETUP:
            begin
                if (cell_inr && !grid_flat)
                begin
                    rhs_next   = rhs_prod;
                    x0_next    = DIM_W'(xs_reg + prod_x[DIM_W-1:0]);
                    y0_next    = DIM_W'(ys_reg + prod_y[DIM_W-1:0]);
                    cx_next    = '0;
                    cy_next    = '0;
                    state_next = ST_BLOCK;
                end
                else
                begin
                    state_next = ST_DONE;
                end
            end
            ST_BLOCK:
            begin
                if (occ_reg)
                begin
                    state_next = ST_BLOCK_END;
                end
                else
                begin
                    blk_vld_next = 1'b1;
                    if (cx_reg == cs_reg - 1'b1)
                    begin
                        cx_next = '0;
                        if (cy_reg == cs_reg - 1'b1)
                            state_next = ST_BLOCK_END;
                        else
                            cy_next = cy_reg + 1'b1;
                    end
                    else
                    begin
                        cx_next = cx_reg + 1'b1;
                    end
                end
            end
            ST_BLOCK_END:
            begin
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    occupied_next  = occ_reg;
                    in_range_next  = cell_inr;
                    flat_next      = grid_flat;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            gw_reg        <= RST_GRID_WIDTH;
            gh_reg        <= RST_GRID_HEIGHT;
            cs_reg        <= RST_CELL_SIDE;
            thr_reg       <= RST_THRESHOLD;
            clr_reg       <= '0;
            scan_vld_reg  <= 1'b0;
            blk_vld_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            gw_reg        <= gw_next;
            gh_reg        <= gh_next;
            cs_reg        <= cs_next;
            thr_reg       <= thr_next;
            clr_reg       <= clr_next;
            scan_vld_reg  <= scan_vld_next;
            blk_vld_reg   <= blk_vld_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        px_reg       <= px_next;
        py_reg       <= py_next;
        cx_reg       <= cx_next;
        cy_reg       <= cy_next;
        first_reg    <= first_next;
        mn_reg       <= mn_next;
        mx_reg       <= mx_next;
        gx_reg       <= gx_next;
        gy_reg       <= gy_next;
        xs_reg       <= xs_next;
        ys_reg       <= ys_next;
        x0_reg       <= x0_next;
        y0_reg       <= y0_next;
        rhs_reg      <= rhs_next;
        occ_reg      <= occ_next;
        occupied_reg <= occupied_next;
        in_range_reg <= in_range_next;
        flat_reg     <= flat_next;
    end

    ogbt_sample_mem #(
        .ADDR_W (ADDR_W),
        .DATA_W (SB)
    ) u_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    ogbt_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    assign out_valid = out_valid_reg;
    assign occupied  = occupied_reg;
    assign in_range  = in_range_reg;
    assign flat      = flat_reg;

    a_occ_needs_cell: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(occupied && (!in_range || flat)))
        else $error("occupied reported outside range or on flat grid");

    a_write_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
        mem_we |-> (state_reg == ST_CLEAR || state_reg == ST_IDLE))
        else $error("sample store written during a query");

    a_reads_drained: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_DONE |-> !scan_vld_reg && !blk_vld_reg)
        else $error("result formed with a read still in flight");

endmodule
